// ----- hw/rtl/bdem_pkg.sv -----
// shared types and constants for the 3x3 binary dilation / erosion unit
`timescale 1ns / 1ps

package bdem_pkg;

   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int MIN_DIM            = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_OP_MODE      = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef enum logic {
      MODE_DILATE = 1'b0,
      MODE_ERODE  = 1'b1
   } mode_type;

   // one column push for the window stage, with the border flags of its result
   typedef struct packed {
      logic newbit;
      logic emit;
      logic r_first;
      logic r_last;
      logic c_first;
      logic c_last;
   } entry_type;

endpackage

// ----- hw/rtl/bdem_channels_if.sv -----
// item channels of the 3x3 binary dilation / erosion unit
`timescale 1ns / 1ps

interface bdem_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic pixel_fg;

   modport source (output valid, output kind, output pixel_fg, input ready);
   modport sink (input valid, input kind, input pixel_fg, output ready);
endinterface

interface bdem_rsp_if;
   logic valid;
   logic ready;
   logic result_fg;
   logic frame_last;

   modport source (output valid, output result_fg, output frame_last, input ready);
   modport sink (input valid, input result_fg, input frame_last, output ready);
endinterface

// ----- hw/rtl/bdem_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bdem_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bdem_front.sv -----
// front end: register writes, raster position tracking and item classification
`timescale 1ns / 1ps

module bdem_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bdem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdem_pkg::CSR_DATA_W-1:0]    csr_wdata,
   bdem_req_if.sink                           req_chan,
   input  logic                               q_full,
   output logic                               push_valid,
   output bdem_pkg::entry_type                push_entry,
   output logic [CW-1:0]                      push_col,
   output bdem_pkg::mode_type                 mode
);

   localparam int WV = (CW >= bdem_pkg::CSR_DATA_W) ? CW + 1 : bdem_pkg::CSR_DATA_W + 1;
   localparam int HV = (RW >= bdem_pkg::CSR_DATA_W) ? RW + 1 : bdem_pkg::CSR_DATA_W + 1;
   localparam int RST_W = (bdem_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                          MAX_WIDTH : bdem_pkg::FRAME_WIDTH_RESET;
   localparam int RST_H = (bdem_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                          MAX_HEIGHT : bdem_pkg::FRAME_HEIGHT_RESET;

   logic [CW-1:0]      wm1_ff, wm1_in;
   logic [RW-1:0]      hm1_ff, hm1_in;
   bdem_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0]      in_col_ff, in_col_in;
   logic [RW-1:0]      in_row_ff, in_row_in;
   logic [CW-1:0]      out_col_ff, out_col_in;
   logic [RW-1:0]      out_row_ff, out_row_in;
   logic               pending_ff, pending_in;

   logic [WV-1:0] w_val, w_clamp;
   logic [HV-1:0] h_val, h_clamp;
   logic          accept, is_pixel, tail, col_last, row_last, emit_pix;
   logic          fl_r_last, fl_c_last;

   // clamp of the written frame size
   always_comb begin
      w_val = WV'(csr_wdata);
      h_val = HV'(csr_wdata);
      if (w_val < WV'(bdem_pkg::MIN_DIM)) begin
         w_clamp = WV'(bdem_pkg::MIN_DIM);
      end else if (w_val > WV'(MAX_WIDTH)) begin
         w_clamp = WV'(MAX_WIDTH);
      end else begin
         w_clamp = w_val;
      end
      if (h_val < HV'(bdem_pkg::MIN_DIM)) begin
         h_clamp = HV'(bdem_pkg::MIN_DIM);
      end else if (h_val > HV'(MAX_HEIGHT)) begin
         h_clamp = HV'(MAX_HEIGHT);
      end else begin
         h_clamp = h_val;
      end
   end

   assign req_chan.ready = !q_full;
   assign accept   = req_chan.valid && !q_full;
   assign is_pixel = (bdem_pkg::kind_type'(req_chan.kind) == bdem_pkg::KIND_PIXEL);
   assign tail     = (in_col_ff == '0) && (in_row_ff == '0) && pending_ff;
   assign col_last = (in_col_ff == wm1_ff);
   assign row_last = (in_row_ff == hm1_ff);
   assign emit_pix = !((in_row_ff == '0) || ((in_row_ff == RW'(1)) && (in_col_ff == '0)));
   assign fl_r_last = (out_row_ff == hm1_ff);
   assign fl_c_last = (out_col_ff == wm1_ff);

   // classification into a window push
   always_comb begin
      push_valid = accept && (is_pixel || tail);
      if (is_pixel) begin
         push_entry.newbit  = req_chan.pixel_fg && (in_row_ff != '0) && !row_last &&
                              (in_col_ff != '0) && !col_last;
         push_entry.emit    = emit_pix;
         push_entry.r_first = ((in_col_ff != '0) && (in_row_ff == RW'(1))) ||
                              ((in_col_ff == '0) && (in_row_ff == RW'(2)));
         push_entry.r_last  = 1'b0;
         push_entry.c_first = (in_col_ff == CW'(1));
         push_entry.c_last  = (in_col_ff == '0);
         push_col           = in_col_ff;
      end else begin
         push_entry.newbit  = 1'b0;
         push_entry.emit    = 1'b1;
         push_entry.r_first = (out_row_ff == '0);
         push_entry.r_last  = fl_r_last;
         push_entry.c_first = (out_col_ff == '0);
         push_entry.c_last  = fl_c_last;
         push_col           = fl_c_last ? '0 : out_col_ff + CW'(1);
      end
   end

   always_comb begin
      wm1_in     = wm1_ff;
      hm1_in     = hm1_ff;
      mode_in    = mode_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (csr_wr_en) begin
         case (bdem_pkg::csr_index_type'(csr_index))
            bdem_pkg::CSR_FRAME_WIDTH: begin
               wm1_in     = CW'(w_clamp - WV'(1));
               in_col_in  = '0;
               in_row_in  = '0;
               pending_in = 1'b0;
            end
            bdem_pkg::CSR_FRAME_HEIGHT: begin
               hm1_in     = RW'(h_clamp - HV'(1));
               in_col_in  = '0;
               in_row_in  = '0;
               pending_in = 1'b0;
            end
            bdem_pkg::CSR_OP_MODE: begin
               mode_in = bdem_pkg::mode_type'(csr_wdata[0]);
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (is_pixel) begin
            if (col_last) begin
               in_col_in = '0;
               in_row_in = row_last ? '0 : in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            if (emit_pix) begin
               pending_in = 1'b1;
               out_row_in = in_row_ff - RW'(1);
               out_col_in = in_col_ff;
            end else if (tail) begin
               pending_in = 1'b0;
            end
         end else if (tail) begin
            if (fl_r_last && fl_c_last) begin
               pending_in = 1'b0;
            end else if (fl_c_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff     <= CW'(RST_W - 1);
         hm1_ff     <= RW'(RST_H - 1);
         mode_ff    <= bdem_pkg::MODE_DILATE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         pending_ff <= 1'b0;
      end else begin
         wm1_ff     <= wm1_in;
         hm1_ff     <= hm1_in;
         mode_ff    <= mode_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
   end

   assign mode = mode_ff;

endmodule

// ----- hw/rtl/bdem_queue.sv -----
// short fifo between the classifying front end and the window back end
`timescale 1ns / 1ps

module bdem_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4,
   localparam int PW = $clog2(DEPTH),
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;

   assign full     = (count_ff == NW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/bdem_back.sv -----
// back end: line store access, 3x3 window and result register
`timescale 1ns / 1ps

module bdem_back #(
   parameter int MAX_WIDTH = 2048,
   localparam int CW = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  bdem_pkg::mode_type  mode,
   input  logic                q_empty,
   input  bdem_pkg::entry_type q_entry,
   input  logic [CW-1:0]       q_col,
   output logic                q_pop,
   bdem_rsp_if.source          rsp_chan
);

   logic                b_valid_ff;
   bdem_pkg::entry_type b_entry_ff;
   logic [CW-1:0]       b_col_ff;
   logic                fwd_ff;
   logic [1:0]          fwd_data_ff;
   logic [8:0]          win_ff;
   logic                rsp_valid_ff;
   logic                rsp_result_ff;
   logic                rsp_last_ff;

   logic       out_free, b_go;
   logic [1:0] rd_data, store_bits, wr_data;
   logic [8:0] win_in, col_mask, row_mask;
   logic       dil, ero, result;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign b_go     = b_valid_ff && (!b_entry_ff.emit || out_free);
   assign q_pop    = !q_empty && (!b_valid_ff || b_go);

   // entry bit 0: two rows up, bit 1: one row up
   bdem_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_go),
      .wr_addr (b_col_ff),
      .wr_data (wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (rd_data)
   );

   assign store_bits = fwd_ff ? fwd_data_ff : rd_data;
   assign wr_data    = {b_entry_ff.newbit, store_bits[1]};
   assign win_in     = {b_entry_ff.newbit, store_bits[1], store_bits[0], win_ff[8:3]};

   always_comb begin
      col_mask = {{3{!b_entry_ff.c_last}}, 3'b111, {3{!b_entry_ff.c_first}}};
      row_mask = {3{!b_entry_ff.r_last, 1'b1, !b_entry_ff.r_first}};
      dil      = |(win_in & col_mask & row_mask);
      ero      = !(b_entry_ff.r_first || b_entry_ff.r_last ||
                   b_entry_ff.c_first || b_entry_ff.c_last) && (&win_in);
      result   = (mode == bdem_pkg::MODE_ERODE) ? ero : dil;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         win_ff       <= '0;
      end else begin
         if (q_pop) begin
            b_valid_ff <= 1'b1;
            fwd_ff     <= b_go && (q_col == b_col_ff);
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go) begin
            win_ff <= win_in;
         end
         if (b_go && b_entry_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_entry_ff  <= q_entry;
         b_col_ff    <= q_col;
         fwd_data_ff <= wr_data;
      end
      if (b_go && b_entry_ff.emit) begin
         rsp_result_ff <= result;
         rsp_last_ff   <= b_entry_ff.r_last && b_entry_ff.c_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.result_fg  = rsp_result_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

endmodule

// ----- hw/rtl/binary_dilate_erode_3x3_unit.sv -----
// top level of the streaming 3x3 binary dilation / erosion unit
// throughput: one item per clock, input and result side stall independently
// path: an accepted item passes the queue, the back-end entry register and the result
//   register; a frame's results trail its pixels by one row plus one item
// reset: 640 x 480 frame, dilation, stream position cleared; line stores keep old
//   contents, which only feed masked border taps of a new frame
`timescale 1ns / 1ps

module binary_dilate_erode_3x3_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bdem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bdem_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bdem_req_if.sink                         req_chan,
   bdem_rsp_if.source                       rsp_chan
);

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int ENTRY_W = $bits(bdem_pkg::entry_type);
   localparam int Q_DEPTH = 4;

   logic                push_valid;
   bdem_pkg::entry_type push_entry;
   logic [CW-1:0]       push_col;
   logic                q_full, q_empty, q_pop;
   logic [ENTRY_W+CW-1:0] q_data;
   bdem_pkg::entry_type pop_entry;
   logic [CW-1:0]       pop_col;
   bdem_pkg::mode_type  mode;

   bdem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_col   (push_col),
      .mode       (mode)
   );

   bdem_queue #(
      .DATA_W (ENTRY_W + CW),
      .DEPTH  (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_col, push_entry}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign pop_entry = bdem_pkg::entry_type'(q_data[ENTRY_W-1:0]);
   assign pop_col   = q_data[ENTRY_W+CW-1:ENTRY_W];

   bdem_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode),
      .q_empty  (q_empty),
      .q_entry  (pop_entry),
      .q_col    (pop_col),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
